@@ hdl/fde_pkg.sv @@
// ----------------------------------------------------------------------------
// fde_pkg: shared types and constants of the framebuffer draw engine
// Command and result word layouts, action and status codes, register indexes.
// ----------------------------------------------------------------------------
package fde_pkg;

  // Largest frame dimension; register writes saturate to it.
  localparam logic [10:0] MAX_DIM = 11'd1024;

  // Width of a working pixel address (line starts plus long strides).
  localparam int ADDR_W = 28;

  // Register indexes on the configuration port.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ACT_FILL      = 3'd0,
    ACT_RESTORE   = 3'd1,
    ACT_CAPTURE   = 3'd2,
    ACT_RECT      = 3'd3,
    ACT_LINE      = 3'd4,
    ACT_SPR_START = 3'd5,
    ACT_SPR_PIX   = 3'd6,
    ACT_READ      = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DROP  = 2'd1,
    ST_NOSPR = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_COPY,
    S_RECT,
    S_LINE,
    S_RADDR,
    S_RWAIT
  } fsm_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [10:0] size_w;
    logic [10:0] size_h;
    logic [15:0] step;
    logic [9:0]  pad_count;
    logic [31:0] color;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
    logic        sprite_done;
  } res_t;

endpackage

@@ hdl/framebuffer_draw_engine_unit.sv @@
// ----------------------------------------------------------------------------
// framebuffer_draw_engine_unit: 32-bit framebuffer draw engine
// Frame and snapshot memories with fill, copy, rectangle, line, sprite and
// pixel read commands, driven by one command word per result word.
// ----------------------------------------------------------------------------
// Usage:
//   A command word enters on cmd/cmd_valid/cmd_stall and exactly one result
//   word leaves on res/res_valid/res_stall. A word moves at a rising edge
//   where valid is high and stall is low. Frame width and height are set on
//   the APB port (byte addresses 0 and 4) while no command is in flight.
//   Sprite pixels and sprite starts are done in the cycle that accepts them.
//   A read passes through address multiply, memory read and result, and
//   skips the memory read when it falls outside the frame. Fill, restore
//   and capture walk the frame area at one pixel a cycle (restore and
//   capture register each memory read before its write); rectangles and
//   lines also write one pixel a cycle. Capture writes the snapshot memory;
//   all other pixel work goes through the single write port of the frame
//   memory. After a sprite start that changes the origin row or sprite row,
//   after a sprite row ends, or after any register write, the next command
//   waits while the row base product is recomputed.
//   Reset clears the sprite state and res_valid and sets the frame
//   to 320 by 200; memory contents are undefined until written. While the
//   receiver stalls, the result word is held and no new command is taken.
// ----------------------------------------------------------------------------
module framebuffer_draw_engine_unit
  import fde_pkg::*;
#(
  parameter int MAX_PIXELS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_t        cmd,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res
);

  localparam int AW = $clog2(MAX_PIXELS);
  localparam int LW = AW + 1;

  // Configuration registers.
  logic [10:0] fw, fh;
  logic        cfg_wr;
  logic [10:0] cfg_val;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_val = (pwdata[10:0] > MAX_DIM) ? MAX_DIM : pwdata[10:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fw <= 11'd320;
      fh <= 11'd200;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) fw <= cfg_val;
      else fh <= cfg_val;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = {21'd0, fw};
      REG_HEIGHT: prdata = {21'd0, fh};
      default:    prdata = '0;
    endcase
  end

  // Usable frame area, limited to the memory depth.
  logic [21:0]       area;
  logic              over;
  logic [LW-1:0]     lim;
  logic [ADDR_W-1:0] limx;

  assign area = 22'(fw) * 22'(fh);
  assign over = area > 22'(MAX_PIXELS);
  assign lim  = over ? LW'(MAX_PIXELS) : area[LW-1:0];
  assign limx = ADDR_W'(lim);

  // Memories.
  logic [31:0]   frame_mem [MAX_PIXELS];
  logic [31:0]   snap_mem  [MAX_PIXELS];
  logic          fwe, swe;
  logic [AW-1:0] fwa, swa, fra, sra;
  logic [31:0]   fwd, swd, frd, srd;

  always_ff @(posedge clk) begin
    if (fwe) frame_mem[fwa] <= fwd;
    frd <= frame_mem[fra];
  end

  always_ff @(posedge clk) begin
    if (swe) snap_mem[swa] <= swd;
    srd <= snap_mem[sra];
  end

  // Control and working registers.
  fsm_t              state, state_next;
  logic [LW-1:0]     idx, idx_next;
  logic              pend, pend_next;
  logic [AW-1:0]     paddr_q, paddr_q_next;
  logic              cdir, cdir_next;
  logic [31:0]       colr, colr_next;
  logic [ADDR_W-1:0] addr, addr_next;
  logic [ADDR_W-1:0] rbase, rbase_next;
  logic [10:0]       cnt, cnt_next;
  logic [10:0]       rows_left, rows_left_next;
  logic [10:0]       rw, rw_next;
  logic [15:0]       stp, stp_next;
  logic              drop, drop_next;

  // Sprite state. The column spans width plus padding, so it needs 12 bits.
  logic [9:0]  spr_ox, spr_ox_next, spr_oy, spr_oy_next, spr_pad, spr_pad_next;
  logic [10:0] spr_w, spr_w_next, spr_h, spr_h_next;
  logic [11:0] spr_col, spr_col_next;
  logic [10:0] spr_row, spr_row_next;
  logic        spr_active, spr_active_next;
  logic [22:0] row_prod;
  logic        prod_ok, prod_upd;

  // Output register.
  logic  ovalid, res_load;
  res_t  ores, res_n;
  logic  res_free, acc;

  action_t           act;
  logic [20:0]       mul_cmd;
  logic [ADDR_W-1:0] cmd_base, raddr, spx_addr;
  logic [11:0]       col1, row1, rowlen;
  logic              issue;

  assign act      = action_t'(cmd.action);
  assign res_free = !ovalid || !res_stall;
  assign cmd_stall = !(state == S_IDLE && res_free && prod_ok);
  assign acc      = cmd_valid && !cmd_stall;
  assign mul_cmd  = 21'(fw) * 21'(cmd.pos_y);
  assign cmd_base = ADDR_W'(mul_cmd) + ADDR_W'(cmd.pos_x);
  assign raddr    = rbase + ADDR_W'(cnt);
  assign spx_addr = ADDR_W'(row_prod) + ADDR_W'(spr_ox) + ADDR_W'(spr_col);
  assign col1     = spr_col + 12'd1;
  assign row1     = 12'(spr_row) + 12'd1;
  assign rowlen   = 12'(spr_w) + 12'(spr_pad);
  assign issue    = idx < lim;

  // Command sequencer: next state, memory ports and result word.
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    pend_next       = 1'b0;
    paddr_q_next    = paddr_q;
    cdir_next       = cdir;
    colr_next       = colr;
    addr_next       = addr;
    rbase_next      = rbase;
    cnt_next        = cnt;
    rows_left_next  = rows_left;
    rw_next         = rw;
    stp_next        = stp;
    drop_next       = drop;
    spr_ox_next     = spr_ox;
    spr_oy_next     = spr_oy;
    spr_w_next      = spr_w;
    spr_h_next      = spr_h;
    spr_pad_next    = spr_pad;
    spr_col_next    = spr_col;
    spr_row_next    = spr_row;
    spr_active_next = spr_active;
    res_load        = 1'b0;
    res_n           = '0;
    fwe             = 1'b0;
    fwa             = idx[AW-1:0];
    fwd             = colr;
    swe             = 1'b0;
    swa             = paddr_q;
    swd             = frd;
    fra             = idx[AW-1:0];
    sra             = idx[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          colr_next = cmd.color;
          unique case (act) inside
            ACT_FILL: begin
              idx_next   = '0;
              state_next = S_FILL;
            end
            ACT_RESTORE, ACT_CAPTURE: begin
              idx_next   = '0;
              cdir_next  = (act == ACT_RESTORE);
              state_next = S_COPY;
            end
            ACT_RECT: begin
              rbase_next     = cmd_base;
              cnt_next       = '0;
              rows_left_next = (cmd.size_h == 11'd0) ? 11'd1 : cmd.size_h;
              rw_next        = cmd.size_w;
              drop_next      = 1'b0;
              state_next     = S_RECT;
            end
            ACT_LINE: begin
              addr_next  = cmd_base;
              cnt_next   = cmd.size_w;
              stp_next   = cmd.step;
              drop_next  = 1'b0;
              state_next = S_LINE;
            end
            ACT_SPR_START: begin
              spr_ox_next     = cmd.pos_x;
              spr_oy_next     = cmd.pos_y;
              spr_w_next      = cmd.size_w;
              spr_h_next      = cmd.size_h;
              spr_pad_next    = cmd.pad_count;
              spr_col_next    = '0;
              spr_row_next    = '0;
              spr_active_next = (cmd.size_h != 11'd0) &&
                                ((12'(cmd.size_w) + 12'(cmd.pad_count)) != 12'd0);
              res_load        = 1'b1;
            end
            ACT_SPR_PIX: begin
              res_load = 1'b1;
              if (!spr_active) begin
                res_n.status = ST_NOSPR;
              end else begin
                // Opaque pixels inside the row are written, the rest skipped.
                if (spr_col < 12'(spr_w) && cmd.color[31:24] != 8'd0) begin
                  if (spx_addr < limx) begin
                    fwe = 1'b1;
                    fwa = spx_addr[AW-1:0];
                    fwd = cmd.color;
                  end else begin
                    res_n.status = ST_DROP;
                  end
                end
                if (col1 >= rowlen) begin
                  spr_col_next = '0;
                  spr_row_next = row1[10:0];
                  if (row1 >= 12'(spr_h)) begin
                    spr_active_next   = 1'b0;
                    res_n.sprite_done = 1'b1;
                  end
                end else begin
                  spr_col_next = col1;
                end
              end
            end
            ACT_READ: begin
              addr_next  = cmd_base;
              state_next = S_RADDR;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_FILL: begin
        if (issue) begin
          fwe      = 1'b1;
          idx_next = idx + LW'(1);
        end else begin
          res_load     = 1'b1;
          res_n.status = over ? ST_DROP : ST_OK;
          state_next   = S_IDLE;
        end
      end
      S_COPY: begin
        // Read one entry per cycle and write it to the other memory in the next cycle.
        idx_next     = idx + LW'(issue);
        pend_next    = issue;
        paddr_q_next = idx[AW-1:0];
        if (pend) begin
          if (cdir) begin
            fwe = 1'b1;
            fwa = paddr_q;
            fwd = srd;
          end else begin
            swe = 1'b1;
          end
        end
        if (!issue && !pend) begin
          res_load     = 1'b1;
          res_n.status = over ? ST_DROP : ST_OK;
          state_next   = S_IDLE;
        end
      end
      S_RECT: begin
        if (rw == 11'd0 || rows_left == 11'd0) begin
          res_load     = 1'b1;
          res_n.status = drop ? ST_DROP : ST_OK;
          state_next   = S_IDLE;
        end else if (cnt == 11'd0 && raddr >= limx) begin
          // A row starting outside the frame ends the rectangle.
          res_load     = 1'b1;
          res_n.status = ST_DROP;
          state_next   = S_IDLE;
        end else begin
          if (raddr < limx) begin
            fwe = 1'b1;
            fwa = raddr[AW-1:0];
          end else begin
            drop_next = 1'b1;
          end
          if (12'(cnt) + 12'd1 == 12'(rw)) begin
            cnt_next       = '0;
            rows_left_next = rows_left - 11'd1;
            rbase_next     = rbase + ADDR_W'(fw);
          end else begin
            cnt_next = cnt + 11'd1;
          end
        end
      end
      S_LINE: begin
        if (cnt == 11'd0) begin
          res_load     = 1'b1;
          res_n.status = drop ? ST_DROP : ST_OK;
          state_next   = S_IDLE;
        end else begin
          if (addr < limx) begin
            fwe = 1'b1;
            fwa = addr[AW-1:0];
          end else begin
            drop_next = 1'b1;
          end
          addr_next = addr + ADDR_W'(stp);
          cnt_next  = cnt - 11'd1;
        end
      end
      S_RADDR: begin
        if (addr < limx) begin
          fra        = addr[AW-1:0];
          state_next = S_RWAIT;
        end else begin
          res_load     = 1'b1;
          res_n.status = ST_DROP;
          state_next   = S_IDLE;
        end
      end
      S_RWAIT: begin
        res_load        = 1'b1;
        res_n.read_data = frd;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The row base product must be recomputed when its inputs change.
  assign prod_upd = cfg_wr || (spr_row_next != spr_row) || (spr_oy_next != spr_oy);

  always_ff @(posedge clk) begin
    row_prod <= 23'(fw) * 23'(12'(spr_oy) + 12'(spr_row));
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend       <= 1'b0;
      spr_active <= 1'b0;
      spr_ox     <= '0;
      spr_oy     <= '0;
      spr_w      <= '0;
      spr_h      <= '0;
      spr_pad    <= '0;
      spr_col    <= '0;
      spr_row    <= '0;
      prod_ok    <= 1'b0;
      ovalid     <= 1'b0;
    end else begin
      state      <= state_next;
      pend       <= pend_next;
      spr_active <= spr_active_next;
      spr_ox     <= spr_ox_next;
      spr_oy     <= spr_oy_next;
      spr_w      <= spr_w_next;
      spr_h      <= spr_h_next;
      spr_pad    <= spr_pad_next;
      spr_col    <= spr_col_next;
      spr_row    <= spr_row_next;
      prod_ok    <= !prod_upd;
      if (res_load) ovalid <= 1'b1;
      else if (!res_stall) ovalid <= 1'b0;
    end
  end

  // Working registers and the result word.
  always_ff @(posedge clk) begin
    idx       <= idx_next;
    paddr_q   <= paddr_q_next;
    cdir      <= cdir_next;
    colr      <= colr_next;
    addr      <= addr_next;
    rbase     <= rbase_next;
    cnt       <= cnt_next;
    rows_left <= rows_left_next;
    rw        <= rw_next;
    stp       <= stp_next;
    drop      <= drop_next;
    if (res_load) ores <= res_n;
  end

  assign res_valid = ovalid;
  assign res       = ores;

  // Checks.
  a_frame_wr_in_area: assert property (@(posedge clk) disable iff (rst)
    fwe |-> (LW'(fwa) < lim))
    else $error("frame write outside the usable area");

  a_snap_wr_in_copy: assert property (@(posedge clk) disable iff (rst)
    swe |-> (state == S_COPY && pend && !cdir))
    else $error("snapshot write outside a capture");

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != ST_OK) |-> (res.read_data == 32'd0))
    else $error("read data on an error result");

  a_sprite_dims: assert property (@(posedge clk) disable iff (rst)
    spr_active |-> (spr_h != 11'd0 && spr_row < spr_h))
    else $error("active sprite with bad row state");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (ovalid && res_stall) |-> !res_load)
    else $error("result loaded over a stalled word");

endmodule
